### sv/cartridge_flash_program_sequencer_unit_defines.svh
// Assertion macros for the sequencer's top-level RTL file.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef CARTRIDGE_FLASH_PROGRAM_SEQUENCER_UNIT_DEFINES_SVH
`define CARTRIDGE_FLASH_PROGRAM_SEQUENCER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define CFSU_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CFSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/cfsu_pkg.sv
`default_nettype none

package cfsu_pkg;

    // Job queue depth between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Width of the back-end step counter (up to six steps per job)
    localparam int STEP_W = 3;

    // Input transaction kind
    localparam logic REQ_HOST = 1'b0;
    localparam logic REQ_BYTE = 1'b1;

    // Configuration register indexes (word address bit 2)
    localparam logic REG_TARGET_BANK = 1'b0;
    localparam logic REG_POLL_LIMIT  = 1'b1;

    localparam logic [15:0] POLL_LIMIT_RESET = 16'hFFFF;

    // Flash unlock and program constants
    localparam logic [15:0] UNLOCK_5V_A   = 16'h5555;
    localparam logic [15:0] UNLOCK_5V_B   = 16'h2AAA;
    localparam logic [15:0] UNLOCK_3V_A   = 16'h0AAA;
    localparam logic [15:0] UNLOCK_3V_B   = 16'h0555;
    localparam logic [15:0] BANK_REG_ADDR = 16'h2000;
    localparam logic [15:0] BANK0_MASK    = 16'h3FFF;
    localparam logic [7:0]  DATA_UNLOCK1  = 8'hAA;
    localparam logic [7:0]  DATA_UNLOCK2  = 8'h55;
    localparam logic [7:0]  DATA_PROGRAM  = 8'hA0;

    // A000-BFFF has top address bits 101
    localparam logic [2:0]  RAM_WIN_TOP   = 3'b101;

    typedef enum logic [2:0] {
        CMD_READ       = 3'd0,
        CMD_WRITE      = 3'd1,
        CMD_FLASH5V    = 3'd2,
        CMD_P31WRITE   = 3'd3,
        CMD_FLASH_BANK = 3'd4,
        CMD_BYPASS     = 3'd5,
        CMD_FLASH3V    = 3'd6,
        CMD_UNKNOWN    = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        CK_READ  = 2'd0,
        CK_WRITE = 2'd1,
        CK_P31   = 2'd2,
        CK_DONE  = 2'd3
    } cycle_kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LIMIT   = 2'd1,
        ST_UNKNOWN = 2'd2
    } done_status_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_READ = 2'd1,
        PH_POLL = 2'd2
    } phase_t;

    // Bus-cycle sequences the back end knows how to play out
    typedef enum logic [2:0] {
        OP_RDCYC  = 3'd0,
        OP_WRITE  = 3'd1,
        OP_P31W   = 3'd2,
        OP_F5V    = 3'd3,
        OP_FBANK  = 3'd4,
        OP_BYPASS = 3'd5,
        OP_F3V    = 3'd6,
        OP_DONE   = 3'd7
    } job_op_t;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  command;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  read_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  cycle_kind;
        logic [15:0] bus_address;
        logic [7:0]  bus_data;
        logic        ram_select;
        logic [1:0]  done_status;
        logic [7:0]  final_byte;
        logic        last;
    } out_item_t;

    typedef struct packed {
        job_op_t      op;
        logic [15:0]  addr;
        logic [7:0]   data;
        logic [7:0]   bank;
        done_status_t status;
        logic [7:0]   fin;
    } job_t;

endpackage

`default_nettype wire

### sv/cfsu_front.sv
`default_nettype none

module cfsu_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  accept,
    input  cfsu_pkg::in_item_t   item,
    input  wire  [7:0]           target_bank,
    input  wire  [15:0]          poll_limit,
    output logic                 job_push,
    output cfsu_pkg::job_t       job
);
    import cfsu_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] pending_reg, pending_next;
    logic [7:0]  expected_reg, expected_next;
    logic [15:0] polls_left_reg, polls_left_next;

    logic [15:0] tgt;
    logic [15:0] polls_dec;

    // Polling state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            pending_reg    <= '0;
            expected_reg   <= '0;
            polls_left_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pending_reg    <= pending_next;
            expected_reg   <= expected_next;
            polls_left_reg <= polls_left_next;
        end
    end

    assign tgt       = (target_bank == 8'd0) ? (item.address & BANK0_MASK) : item.address;
    assign polls_dec = polls_left_reg - 16'd1;

    // Classify the transaction and build the job for the back end
    always_comb
    begin
        phase_next      = phase_reg;
        pending_next    = pending_reg;
        expected_next   = expected_reg;
        polls_left_next = polls_left_reg;
        job_push        = 1'b0;
        job.op          = OP_DONE;
        job.addr        = item.address;
        job.data        = item.write_data;
        job.bank        = target_bank;
        job.status      = ST_OK;
        job.fin         = 8'd0;

        if (accept)
        begin
            if (item.req_type == REQ_BYTE)
            begin
                job.fin = item.read_byte;
                case (phase_reg)
                    PH_READ:
                    begin
                        job_push   = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    PH_POLL:
                    begin
                        job_push = 1'b1;
                        if (item.read_byte == expected_reg)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            polls_left_next = polls_dec;
                            if (polls_dec == 16'd0)
                            begin
                                job.status = ST_LIMIT;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                job.op   = OP_RDCYC;
                                job.addr = pending_reg;
                            end
                        end
                    end
                    default:
                    begin
                        // byte with nothing pending: dropped
                    end
                endcase
            end
            else
            begin
                job_push   = 1'b1;
                phase_next = PH_IDLE;
                case (cmd_t'(item.command))
                    CMD_READ:
                    begin
                        job.op       = OP_RDCYC;
                        pending_next = item.address;
                        phase_next   = PH_READ;
                    end
                    CMD_WRITE:    job.op = OP_WRITE;
                    CMD_P31WRITE: job.op = OP_P31W;
                    CMD_FLASH5V:
                    begin
                        job.op          = OP_F5V;
                        pending_next    = item.address;
                        expected_next   = item.write_data;
                        polls_left_next = poll_limit;
                        phase_next      = PH_POLL;
                    end
                    CMD_FLASH_BANK, CMD_BYPASS, CMD_FLASH3V:
                    begin
                        case (cmd_t'(item.command))
                            CMD_FLASH_BANK: job.op = OP_FBANK;
                            CMD_BYPASS:     job.op = OP_BYPASS;
                            default:        job.op = OP_F3V;
                        endcase
                        job.addr        = tgt;
                        pending_next    = tgt;
                        expected_next   = item.write_data;
                        polls_left_next = poll_limit;
                        phase_next      = PH_POLL;
                    end
                    default:
                    begin
                        job.op     = OP_DONE;
                        job.status = ST_UNKNOWN;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

### sv/cfsu_queue.sv
`default_nettype none

module cfsu_queue #(
    parameter int DEPTH = cfsu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              wr_en,
    input  cfsu_pkg::job_t   wr_data,
    output logic             full,
    input  wire              rd_en,
    output cfsu_pkg::job_t   rd_data,
    output logic             empty
);
    import cfsu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### sv/cfsu_back.sv
`default_nettype none

module cfsu_back (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  job_valid,
    input  cfsu_pkg::job_t       job,
    output logic                 job_pop,
    output cfsu_pkg::out_item_t  result,
    output logic                 empty,
    input  wire                  pop
);
    import cfsu_pkg::*;

    logic [STEP_W-1:0] step_reg;
    out_item_t         result_reg;
    logic              result_valid_reg;

    cycle_kind_t       kind;
    logic [15:0]       addr;
    logic [7:0]        data;
    logic              step_last;
    logic              adv;
    out_item_t         cur;

    // Bus cycle for the current job step
    always_comb
    begin
        kind      = CK_DONE;
        addr      = job.addr;
        data      = job.data;
        step_last = 1'b0;
        case (job.op)
            OP_RDCYC:
            begin
                kind      = CK_READ;
                step_last = 1'b1;
            end
            OP_WRITE, OP_P31W:
            begin
                kind      = (step_reg == STEP_W'(0))
                          ? ((job.op == OP_WRITE) ? CK_WRITE : CK_P31) : CK_DONE;
                step_last = (step_reg != STEP_W'(0));
            end
            OP_F5V, OP_F3V:
            begin
                kind      = (job.op == OP_F5V) ? CK_WRITE : CK_P31;
                step_last = (step_reg == STEP_W'(3));
                case (step_reg)
                    STEP_W'(0):
                    begin
                        addr = (job.op == OP_F5V) ? UNLOCK_5V_A : UNLOCK_3V_A;
                        data = DATA_UNLOCK1;
                    end
                    STEP_W'(1):
                    begin
                        addr = (job.op == OP_F5V) ? UNLOCK_5V_B : UNLOCK_3V_B;
                        data = DATA_UNLOCK2;
                    end
                    STEP_W'(2):
                    begin
                        addr = (job.op == OP_F5V) ? UNLOCK_5V_A : UNLOCK_3V_A;
                        data = DATA_PROGRAM;
                    end
                    default:
                    begin
                        // program cycle at the target
                    end
                endcase
            end
            OP_FBANK:
            begin
                kind      = CK_P31;
                step_last = (step_reg == STEP_W'(5))
                         || ((step_reg == STEP_W'(4)) && (job.bank == 8'd0));
                case (step_reg)
                    STEP_W'(0):
                    begin
                        kind = CK_WRITE;
                        addr = BANK_REG_ADDR;
                        data = 8'd0;
                    end
                    STEP_W'(1):
                    begin
                        addr = UNLOCK_5V_A;
                        data = DATA_UNLOCK1;
                    end
                    STEP_W'(2):
                    begin
                        addr = UNLOCK_5V_B;
                        data = DATA_UNLOCK2;
                    end
                    STEP_W'(3):
                    begin
                        addr = UNLOCK_5V_A;
                        data = DATA_PROGRAM;
                    end
                    STEP_W'(4):
                    begin
                        // bank register write only for a nonzero bank
                        if (job.bank != 8'd0)
                        begin
                            kind = CK_WRITE;
                            addr = BANK_REG_ADDR;
                            data = job.bank;
                        end
                    end
                    default:
                    begin
                        // program cycle at the target
                    end
                endcase
            end
            OP_BYPASS:
            begin
                kind      = CK_P31;
                step_last = (step_reg != STEP_W'(0));
                if (step_reg == STEP_W'(0))
                begin
                    data = DATA_PROGRAM;
                end
            end
            default:
            begin
                kind      = CK_DONE;
                step_last = 1'b1;
            end
        endcase
    end

    // Result fields; bus fields zero on done, done fields zero on bus cycles
    always_comb
    begin
        cur.cycle_kind  = kind;
        cur.bus_address = (kind == CK_DONE) ? 16'd0 : addr;
        cur.bus_data    = (kind == CK_WRITE || kind == CK_P31) ? data : 8'd0;
        cur.ram_select  = (kind != CK_DONE) && (addr[15:13] == RAM_WIN_TOP);
        cur.done_status = (kind == CK_DONE) ? job.status : ST_OK;
        cur.final_byte  = (kind == CK_DONE) ? job.fin : 8'd0;
        cur.last        = step_last;
    end

    assign adv     = job_valid && (!result_valid_reg || pop);
    assign job_pop = adv && step_last;
    assign result  = result_reg;
    assign empty   = !result_valid_reg;

    // Step counter and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            step_reg         <= step_last ? '0 : step_reg + 1'b1;
            result_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= cur;
        end
    end

endmodule

`default_nettype wire

### sv/cartridge_flash_program_sequencer_unit.sv
// Cartridge flash program sequencer. Host commands and returned read bytes enter
// through a queue-style input (push/full); bus-cycle and done transactions leave
// through a queue-style output (empty/pop), one per clock while jobs are queued
// and pop keeps up. The front end classifies each input combinationally and in
// the same cycle places a job in a QUEUE_DEPTH-entry queue (default 2); the back
// end plays a job out as a run of results: one for a read, returned byte or unknown
// command, two for writes and unlock-bypass, four for the 5V and 3V programs, five or
// six for the banked program (six when target_bank is nonzero). The back end's step
// counter sets the sustained rate; input is taken every cycle while the job queue has
// room. Registers sit at paddr 0 (target_bank) and 4 (poll_limit, reset FFFF; 0 allows
// 65536 polls) and should be written only while the block is idle.
`default_nettype none

`include "cartridge_flash_program_sequencer_unit_defines.svh"

module cartridge_flash_program_sequencer_unit #(
    parameter int QUEUE_DEPTH = cfsu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    output logic                 full,
    input  cfsu_pkg::in_item_t   item,
    output logic                 empty,
    input  wire                  pop,
    output cfsu_pkg::out_item_t  result,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [2:0]           paddr,
    input  wire  [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import cfsu_pkg::*;

    logic [7:0]  target_bank_reg;
    logic [15:0] poll_limit_reg;
    logic        cfg_wr;
    logic        in_accept;
    logic        job_push;
    job_t        job_in;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    job_t        job_head;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_bank_reg <= '0;
            poll_limit_reg  <= POLL_LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_TARGET_BANK)
            begin
                target_bank_reg <= pwdata[7:0];
            end
            else
            begin
                poll_limit_reg <= pwdata[15:0];
            end
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_TARGET_BANK: prdata = {24'd0, target_bank_reg};
            REG_POLL_LIMIT:  prdata = {16'd0, poll_limit_reg};
            default:         prdata = '0;
        endcase
    end

    // Input side
    assign full      = q_full;
    assign in_accept = push && !q_full;

    cfsu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .item        (item),
        .target_bank (target_bank_reg),
        .poll_limit  (poll_limit_reg),
        .job_push    (job_push),
        .job         (job_in)
    );

    cfsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (job_head),
        .empty   (q_empty)
    );

    cfsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_empty),
        .job       (job_head),
        .job_pop   (q_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

    // Checks
    `CFSU_ASSERT_IMPLY(a_no_job_overflow, job_push, !q_full, "job pushed into a full queue")
    `CFSU_ASSERT_NEXT(a_job_end_leaves_result, q_pop, !empty, "finished job left no result")
    `CFSU_ASSERT_IMPLY(a_done_has_no_bus, !empty && result.cycle_kind == CK_DONE, result.bus_address == 16'd0 && result.bus_data == 8'd0 && result.ram_select == 1'b0, "done transaction drives bus fields")
    `CFSU_ASSERT_IMPLY(a_ram_select_window, !empty && result.cycle_kind != CK_DONE, result.ram_select == (result.bus_address[15:13] == RAM_WIN_TOP), "ram_select disagrees with address")

endmodule

`default_nettype wire
